FILE: design/rsi_pkg.sv
// Shared types, widths and register codes for the ray and sphere intersection block.
`default_nettype none
package rsi_pkg;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int COORD_W        = 32;
    localparam int RADIUS_W       = 31;
    localparam int CFG_IDX_W      = 2;
    localparam int IN_TDATA_W     = 7 * COORD_W;
    localparam int VW             = 33;
    localparam int AW             = 64;
    localparam int BW             = 66;
    localparam int CW             = 67;
    localparam int QW             = 132;
    localparam int SW             = 66;
    localparam int NUMW           = 68;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_RADIUS
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RADIUS_W-1:0]       radius;
    } t_sphere;

    typedef struct packed {
        logic                      nohit;
        logic [QW-1:0]             q;
        logic signed [BW-1:0]      b;
        logic [AW-1:0]             a;
        logic signed [COORD_W-1:0] tmin;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;
endpackage
`default_nettype wire

FILE: design/ray_sphere_intersect.sv
// Top level of the ray and sphere intersection block.
// Throughput: one ray per cycle, set by the fully pipelined front, square-root and divider stages,
// while the queue has room and the output is accepted.
// The longest sections are the 66-step square root and the (67 + FRAC_BITS)-step divider.
// Reset is synchronous and active low; it clears the pipeline valids and the queue and
// sets the sphere to center zero and radius one.
`default_nettype none
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [COORD_W-1:0]    i_cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z, min_distance
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // hit_distance
    output logic [COORD_W-1:0]         m_tdata,
    // hit
    output logic                       m_tuser
);
    t_sphere    r_sphere;
    logic       front_en, front_valid, fifo_push, fifo_pop;
    t_item      front_item, fifo_item;
    t_fifo_stat fifo_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sphere.cx     <= '0;
            r_sphere.cy     <= '0;
            r_sphere.cz     <= '0;
            r_sphere.radius <= RADIUS_W'(65536);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_sphere.cx     <= i_cfg_wdata;
                CFG_CENTER_Y: r_sphere.cy     <= i_cfg_wdata;
                CFG_CENTER_Z: r_sphere.cz     <= i_cfg_wdata;
                CFG_RADIUS:   r_sphere.radius <= i_cfg_wdata[RADIUS_W-1:0];
                default:      r_sphere        <= r_sphere;
            endcase
        end
    end

    assign front_en  = !(front_valid && fifo_stat.full);
    assign fifo_push = front_en && front_valid;
    assign s_tready  = front_en;

    rsi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (front_en),
        .i_valid  (s_tvalid),
        .i_data   (s_tdata),
        .i_sphere (r_sphere),
        .o_valid  (front_valid),
        .o_item   (front_item)
    );

    rsi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (front_item),
        .i_pop   (fifo_pop),
        .o_data  (fifo_item),
        .o_stat  (fifo_stat)
    );

    rsi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (!fifo_stat.empty),
        .i_item      (fifo_item),
        .o_pop       (fifo_pop),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_hit       (m_tuser),
        .o_dist      (m_tdata)
    );

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_push |-> !fifo_stat.full)
        else $error("queue written while full");

    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_pop |-> !fifo_stat.empty)
        else $error("queue read while empty");

    ap_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_stat.full && !fifo_pop) |=> fifo_stat.full)
        else $error("full queue lost an entry without a read");

    ap_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss result carries a nonzero distance");
endmodule
`default_nettype wire

FILE: design/rsi_front.sv
// Front pipeline: forms the quadratic coefficients and the discriminant of each ray.
`default_nettype none
module rsi_front
    import rsi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [IN_TDATA_W-1:0] i_data,
    input  wire t_sphere               i_sphere,
    output logic                       o_valid,
    output t_item                      o_item
);
    logic [7:1] r_v;

    logic signed [VW-1:0]      r_vx, r_vy, r_vz, n_vx, n_vy, n_vz;
    logic signed [COORD_W-1:0] r_dx, r_dy, r_dz;
    logic signed [COORD_W-1:0] r_tmin1, r_tmin2, r_tmin3, r_tmin4, r_tmin5, r_tmin6;

    logic signed [63:0] r_dxx, r_dyy, r_dzz;
    logic signed [64:0] r_vdx, r_vdy, r_vdz;
    logic signed [65:0] r_vvx, r_vvy, r_vvz;
    logic [61:0]        r_rr;

    logic [AW-1:0]        r_a3, r_a4, r_a5, r_a6;
    logic signed [BW-1:0] r_b3, r_b4, r_b5, r_b6;
    logic signed [CW-1:0] r_c3;
    logic                 r_az3, r_az4, r_az5, r_az6;

    logic [BW-2:0] r_bm;
    logic [CW-2:0] r_cm;
    logic          r_cs4, r_cs5, r_cs6;

    logic [63:0] r_pbb [0:2][0:2];
    logic [63:0] r_pac [0:1][0:2];
    logic [63:0] n_pbb [0:2][0:2];
    logic [63:0] n_pac [0:1][0:2];
    logic [95:0] n_bm96, n_cm96;

    logic [QW-1:0] r_bb, r_ac, n_bb, n_ac;

    t_item r_item;

    assign n_vx = VW'($signed(i_data[0*COORD_W +: COORD_W])) - VW'(i_sphere.cx);
    assign n_vy = VW'($signed(i_data[1*COORD_W +: COORD_W])) - VW'(i_sphere.cy);
    assign n_vz = VW'($signed(i_data[2*COORD_W +: COORD_W])) - VW'(i_sphere.cz);

    always_comb begin
        n_bm96 = {{(96-(BW-1)){1'b0}}, r_bm};
        n_cm96 = {{(96-(CW-1)){1'b0}}, r_cm};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pbb[i][j] = n_bm96[32*i +: 32] * n_bm96[32*j +: 32];
            end
        end
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pac[i][j] = r_a4[32*i +: 32] * n_cm96[32*j +: 32];
            end
        end
    end

    always_comb begin
        n_bb = '0;
        n_ac = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_bb = n_bb + (QW'(r_pbb[i][j]) << (32 * (i + j)));
            end
        end
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_ac = n_ac + (QW'(r_pac[i][j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx    <= n_vx;
            r_vy    <= n_vy;
            r_vz    <= n_vz;
            r_dx    <= $signed(i_data[3*COORD_W +: COORD_W]);
            r_dy    <= $signed(i_data[4*COORD_W +: COORD_W]);
            r_dz    <= $signed(i_data[5*COORD_W +: COORD_W]);
            r_tmin1 <= $signed(i_data[6*COORD_W +: COORD_W]);

            r_dxx   <= r_dx * r_dx;
            r_dyy   <= r_dy * r_dy;
            r_dzz   <= r_dz * r_dz;
            r_vdx   <= r_vx * r_dx;
            r_vdy   <= r_vy * r_dy;
            r_vdz   <= r_vz * r_dz;
            r_vvx   <= r_vx * r_vx;
            r_vvy   <= r_vy * r_vy;
            r_vvz   <= r_vz * r_vz;
            r_rr    <= 62'(i_sphere.radius) * 62'(i_sphere.radius);
            r_tmin2 <= r_tmin1;

            r_a3    <= $unsigned(r_dxx) + $unsigned(r_dyy) + $unsigned(r_dzz);
            r_az3   <= (r_dxx == '0) && (r_dyy == '0) && (r_dzz == '0);
            r_b3    <= BW'(r_vdx) + BW'(r_vdy) + BW'(r_vdz);
            r_c3    <= CW'(r_vvx) + CW'(r_vvy) + CW'(r_vvz) - CW'(r_rr);
            r_tmin3 <= r_tmin2;

            r_bm    <= (BW-1)'(r_b3[BW-1] ? -r_b3 : r_b3);
            r_cm    <= (CW-1)'(r_c3[CW-1] ? -r_c3 : r_c3);
            r_cs4   <= r_c3[CW-1];
            r_a4    <= r_a3;
            r_az4   <= r_az3;
            r_b4    <= r_b3;
            r_tmin4 <= r_tmin3;

            r_pbb   <= n_pbb;
            r_pac   <= n_pac;
            r_cs5   <= r_cs4;
            r_a5    <= r_a4;
            r_az5   <= r_az4;
            r_b5    <= r_b4;
            r_tmin5 <= r_tmin4;

            r_bb    <= n_bb;
            r_ac    <= n_ac;
            r_cs6   <= r_cs5;
            r_a6    <= r_a5;
            r_az6   <= r_az5;
            r_b6    <= r_b5;
            r_tmin6 <= r_tmin5;

            r_item.q     <= r_cs6 ? (r_bb + r_ac) : (r_bb - r_ac);
            r_item.nohit <= r_az6 || (r_cs6 ? 1'b0 : (r_bb < r_ac));
            r_item.b     <= r_b6;
            r_item.a     <= r_a6;
            r_item.tmin  <= r_tmin6;
        end
    end

    assign o_valid = r_v[7];
    assign o_item  = r_item;
endmodule
`default_nettype wire

FILE: design/rsi_fifo.sv
// Short queue that decouples the front pipeline from the back pipeline.
`default_nettype none
module rsi_fifo
    import rsi_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    input  wire logic  i_pop,
    output t_item      o_data,
    output t_fifo_stat o_stat
);
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNTW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
endmodule
`default_nettype wire

FILE: design/rsi_div.sv
// Pipelined restoring divider: two dividends over one shared divisor, one bit per stage.
`default_nettype none
module rsi_div
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [AW-1:0]                 i_a,
    input  wire logic [NUMW-2:0]               i_mag_near,
    input  wire logic [NUMW-2:0]               i_mag_far,
    input  wire logic [SIDE_W-1:0]             i_side,
    output logic                               o_valid,
    output logic [NUMW-2+FRAC_BITS:0]          o_q_near,
    output logic [NUMW-2+FRAC_BITS:0]          o_q_far,
    output logic                               o_nz_near,
    output logic                               o_nz_far,
    output logic [SIDE_W-1:0]                  o_side
);
    localparam int NW = NUMW - 1 + FRAC_BITS;

    logic [NW-1:0]     r_xn   [0:NW];
    logic [NW-1:0]     r_xf   [0:NW];
    logic [AW-1:0]     r_rn   [0:NW];
    logic [AW-1:0]     r_rf   [0:NW];
    logic [AW-1:0]     r_a    [0:NW];
    logic [SIDE_W-1:0] r_side [0:NW];
    logic [NW:0]       r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xn[0]   <= {i_mag_near, {FRAC_BITS{1'b0}}};
            r_xf[0]   <= {i_mag_far, {FRAC_BITS{1'b0}}};
            r_rn[0]   <= '0;
            r_rf[0]   <= '0;
            r_a[0]    <= i_a;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < NW; g++) begin : g_step
        logic [AW:0] n_tn, n_tf, n_dn, n_df;
        logic        n_gn, n_gf;

        assign n_tn = {r_rn[g], r_xn[g][NW-1]};
        assign n_tf = {r_rf[g], r_xf[g][NW-1]};
        assign n_gn = n_tn >= {1'b0, r_a[g]};
        assign n_gf = n_tf >= {1'b0, r_a[g]};
        assign n_dn = n_tn - {1'b0, r_a[g]};
        assign n_df = n_tf - {1'b0, r_a[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rn[g+1]   <= n_gn ? n_dn[AW-1:0] : n_tn[AW-1:0];
                r_rf[g+1]   <= n_gf ? n_df[AW-1:0] : n_tf[AW-1:0];
                r_xn[g+1]   <= {r_xn[g][NW-2:0], n_gn};
                r_xf[g+1]   <= {r_xf[g][NW-2:0], n_gf};
                r_a[g+1]    <= r_a[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid   = r_v[NW];
    assign o_q_near  = r_xn[NW];
    assign o_q_far   = r_xf[NW];
    assign o_nz_near = (r_rn[NW] != '0);
    assign o_nz_far  = (r_rf[NW] != '0);
    assign o_side    = r_side[NW];
endmodule
`default_nettype wire

FILE: design/rsi_back.sv
// Back pipeline: square root, both roots, root selection and the output register.
`default_nettype none
module rsi_back
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_avail,
    input  wire t_item               i_item,
    output logic                     o_pop,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_hit,
    output logic [COORD_W-1:0]       o_dist
);
    localparam int RW     = SW + 2;
    localparam int NW     = NUMW - 1 + FRAC_BITS;
    localparam int TW     = NW + 1;
    localparam int SIDE_W = COORD_W + 3;
    localparam logic signed [TW-1:0] T_MAX = TW'(2147483647);
    localparam logic signed [TW-1:0] T_MIN = -T_MAX - 1;

    logic en;

    t_item         r_sq_item [0:SW];
    logic [RW-1:0] r_sq_rem  [0:SW];
    logic [SW-1:0] r_sq_root [0:SW];
    logic [SW:0]   r_sq_v;

    logic signed [NUMW-1:0]    r_num_near, r_num_far, n_num_near, n_num_far, n_bx, n_sx;
    logic [NUMW-1:0]           n_abs_near, n_abs_far;
    logic [AW-1:0]             r_n_a;
    logic signed [COORD_W-1:0] r_n_tmin;
    logic                      r_n_nohit, r_n_v;

    logic              d_valid, d_nz_near, d_nz_far;
    logic [NW-1:0]     d_q_near, d_q_far;
    logic [SIDE_W-1:0] d_side;

    logic signed [TW-1:0]      r_t_near, r_t_far, n_t_near, n_t_far, n_tminx, n_sel;
    logic signed [COORD_W-1:0] r_t_tmin;
    logic                      r_t_nohit, r_t_v;

    logic                      n_ge_near, n_ge_far, n_hit;
    logic [COORD_W-1:0]        n_sat;
    logic                      r_out_valid, r_hit;
    logic [COORD_W-1:0]        r_dist;

    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= '0;
        end else if (en) begin
            r_sq_v <= {r_sq_v[SW-1:0], i_avail};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_item[0] <= i_item;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        logic [RW-1:0] n_cur, n_trial;
        logic          n_ge;
        t_item         n_item;

        assign n_cur   = {r_sq_rem[g][RW-3:0], r_sq_item[g].q[QW-1 -: 2]};
        assign n_trial = {r_sq_root[g], 2'b01};
        assign n_ge    = n_cur >= n_trial;

        always_comb begin
            n_item   = r_sq_item[g];
            n_item.q = {r_sq_item[g].q[QW-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[g+1]  <= n_ge ? (n_cur - n_trial) : n_cur;
                r_sq_root[g+1] <= {r_sq_root[g][SW-2:0], n_ge};
                r_sq_item[g+1] <= n_item;
            end
        end
    end

    assign n_bx       = {{(NUMW-BW){r_sq_item[SW].b[BW-1]}}, r_sq_item[SW].b};
    assign n_sx       = {{(NUMW-SW){1'b0}}, r_sq_root[SW]};
    assign n_num_near = -n_bx - n_sx;
    assign n_num_far  = n_sx - n_bx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (en) begin
            r_n_v <= r_sq_v[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_near <= n_num_near;
            r_num_far  <= n_num_far;
            r_n_a      <= r_sq_item[SW].a;
            r_n_tmin   <= r_sq_item[SW].tmin;
            r_n_nohit  <= r_sq_item[SW].nohit;
        end
    end

    assign n_abs_near = r_num_near[NUMW-1] ? -r_num_near : r_num_near;
    assign n_abs_far  = r_num_far[NUMW-1] ? -r_num_far : r_num_far;

    rsi_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_n_v),
        .i_a        (r_n_a),
        .i_mag_near (n_abs_near[NUMW-2:0]),
        .i_mag_far  (n_abs_far[NUMW-2:0]),
        .i_side     ({r_n_nohit, r_n_tmin, r_num_near[NUMW-1], r_num_far[NUMW-1]}),
        .o_valid    (d_valid),
        .o_q_near   (d_q_near),
        .o_q_far    (d_q_far),
        .o_nz_near  (d_nz_near),
        .o_nz_far   (d_nz_far),
        .o_side     (d_side)
    );

    // Floor division: a negative dividend with a remainder rounds one further down.
    assign n_t_near = d_side[1] ? (~{1'b0, d_q_near} + TW'(!d_nz_near)) : {1'b0, d_q_near};
    assign n_t_far  = d_side[0] ? (~{1'b0, d_q_far} + TW'(!d_nz_far)) : {1'b0, d_q_far};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (en) begin
            r_t_v <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_near  <= n_t_near;
            r_t_far   <= n_t_far;
            r_t_tmin  <= d_side[2 +: COORD_W];
            r_t_nohit <= d_side[SIDE_W-1];
        end
    end

    assign n_tminx   = {{(TW-COORD_W){r_t_tmin[COORD_W-1]}}, r_t_tmin};
    assign n_ge_near = r_t_near >= n_tminx;
    assign n_ge_far  = r_t_far >= n_tminx;
    assign n_hit     = !r_t_nohit && (n_ge_near || n_ge_far);
    assign n_sel     = n_ge_near ? r_t_near : r_t_far;

    always_comb begin
        if (n_sel > T_MAX) begin
            n_sat = T_MAX[COORD_W-1:0];
        end else if (n_sel < T_MIN) begin
            n_sat = T_MIN[COORD_W-1:0];
        end else begin
            n_sat = n_sel[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= n_hit;
            r_dist <= n_hit ? n_sat : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_dist      = r_dist;
endmodule
`default_nettype wire
